// ===== hdl/sjci_pkg.sv =====
// Shared types, codes and reset constants for the servo jog command interpreter.
`timescale 1ns / 1ps

package sjci_pkg;

  // Default number of servos kept by the block.
  localparam int SERVO_COUNT_DEF = 6;

  // Field widths.
  localparam int PULSE_W    = 12;
  localparam int TIMEOUT_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_HOME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOWER_HOME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_TIMEOUT = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [PULSE_W-1:0]   RST_SERVO_MIN     = 12'd150;
  localparam logic [PULSE_W-1:0]   RST_SERVO_MAX     = 12'd600;
  localparam logic [PULSE_W-1:0]   RST_LEADER_HOME   = 12'd600;
  localparam logic [PULSE_W-1:0]   RST_FOLLOWER_HOME = 12'd150;
  localparam logic [TIMEOUT_W-1:0] RST_DIGIT_TIMEOUT = 10'd50;

  // Fixed home pulses of servos 0 to 3.
  localparam logic [PULSE_W-1:0] FIXED_HOME [4] = '{12'd430, 12'd190, 12'd510, 12'd440};

  // Step size after reset.
  localparam logic [PULSE_W-1:0] RST_STEP = 12'd5;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_IDLE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SELECTED  = 3'd1,
    EV_MOVED     = 3'd2,
    EV_STEP_SET  = 3'd3,
    EV_STEP_REJ  = 3'd4,
    EV_EXIT      = 3'd5,
    EV_RESTARTED = 3'd6,
    EV_RSVD      = 3'd7
  } event_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    event_t             event_res;
    logic [2:0]         channel;
    logic [PULSE_W-1:0] pulse;
    logic               follower_moved;
    logic [PULSE_W-1:0] follower_pulse;
    logic [PULSE_W-1:0] step_now;
  } result_t;

  typedef struct packed {
    logic [PULSE_W-1:0]   servo_min;
    logic [PULSE_W-1:0]   servo_max;
    logic [PULSE_W-1:0]   leader_home;
    logic [PULSE_W-1:0]   follower_home;
    logic [TIMEOUT_W-1:0] digit_timeout;
  } cfg_t;

endpackage

// ===== hdl/sjci_cfg_regs.sv =====
// Configuration register bank of the servo jog command interpreter.
`timescale 1ns / 1ps

module sjci_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sjci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sjci_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sjci_pkg::cfg_t                   cfg
);
  import sjci_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_min     <= RST_SERVO_MIN;
      cfg_r.servo_max     <= RST_SERVO_MAX;
      cfg_r.leader_home   <= RST_LEADER_HOME;
      cfg_r.follower_home <= RST_FOLLOWER_HOME;
      cfg_r.digit_timeout <= RST_DIGIT_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SERVO_MIN:     cfg_r.servo_min     <= cfg_wdata[PULSE_W-1:0];
        REG_SERVO_MAX:     cfg_r.servo_max     <= cfg_wdata[PULSE_W-1:0];
        REG_LEADER_HOME:   cfg_r.leader_home   <= cfg_wdata[PULSE_W-1:0];
        REG_FOLLOWER_HOME: cfg_r.follower_home <= cfg_wdata[PULSE_W-1:0];
        REG_DIGIT_TIMEOUT: cfg_r.digit_timeout <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/sjci_core.sv =====
// Interpreter state and the single-pass next-state and result logic.
`timescale 1ns / 1ps

module sjci_core #(
  parameter int SERVO_COUNT = sjci_pkg::SERVO_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  sjci_pkg::in_item_t item,
  input  sjci_pkg::cfg_t     cfg,
  output sjci_pkg::result_t  result
);
  import sjci_pkg::*;

  localparam int SEL_W        = $clog2(SERVO_COUNT);
  localparam int LEADER_IDX   = 4;
  localparam int FOLLOWER_IDX = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_U  = 8'h44;  // D
  localparam logic [7:0] CH_UP_L  = 8'h64;  // d
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DN_U  = 8'h41;  // A
  localparam logic [7:0] CH_DN_L  = 8'h61;  // a
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STEP_U = 8'h53; // S
  localparam logic [7:0] CH_STEP_L = 8'h73; // s
  localparam logic [7:0] CH_EXIT_U = 8'h4D; // M
  localparam logic [7:0] CH_EXIT_L = 8'h6D; // m

  logic [PULSE_W-1:0]   pos_r   [SERVO_COUNT];
  logic [PULSE_W-1:0]   pos_nxt [SERVO_COUNT];
  logic [SEL_W-1:0]     sel_r, sel_nxt;
  logic [PULSE_W-1:0]   step_r, step_nxt;
  logic                 coll_r, coll_nxt;
  logic [PULSE_W-1:0]   dv_r, dv_nxt;
  logic [TIMEOUT_W-1:0] et_r, et_nxt;

  logic [7:0]           c;
  logic [7:0]           c_off;
  logic                 is_digit, is_sel, is_up, is_down;
  logic [PULSE_W-1:0]   p_cur, p_new;
  logic [PULSE_W:0]     up_sum, up_val;
  logic [PULSE_W-1:0]   dn_val;
  logic signed [PULSE_W+1:0] mirror_raw, mirror_hi;
  logic [PULSE_W-1:0]   mirror_val;
  logic [15:0]          dv_acc;
  logic [PULSE_W-1:0]   dv_sat;
  logic [TIMEOUT_W-1:0] et_inc;
  result_t              res;

  // Home pulse of a servo, used by restart.
  function automatic logic [PULSE_W-1:0] home_pulse(input int idx, input cfg_t cv);
    logic [PULSE_W-1:0] h;
    if (idx < 4)                 h = FIXED_HOME[idx];
    else if (idx == LEADER_IDX)  h = cv.leader_home;
    else if (idx == FOLLOWER_IDX) h = cv.follower_home;
    else                         h = cv.servo_min;
    return h;
  endfunction

  assign c        = item.byte_value;
  assign c_off    = c - CH_ZERO;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sel   = (c >= CH_ZERO) && (c_off < 8'(SERVO_COUNT));
  assign is_up    = (c == CH_UP_U) || (c == CH_UP_L) || (c == CH_PLUS);
  assign is_down  = (c == CH_DN_U) || (c == CH_DN_L) || (c == CH_MINUS);

  // Jog arithmetic on the selected pulse.
  assign p_cur  = pos_r[sel_r];
  assign up_sum = {1'b0, p_cur} + {1'b0, step_r};

  always_comb begin
    up_val = (p_cur < cfg.servo_max) ? up_sum : {1'b0, p_cur};
    if (up_val > {1'b0, cfg.servo_max}) up_val = {1'b0, cfg.servo_max};

    dn_val = p_cur;
    if (p_cur > cfg.servo_min) dn_val = (step_r > p_cur) ? '0 : p_cur - step_r;
    if (dn_val < cfg.servo_min) dn_val = cfg.servo_min;

    p_new = is_up ? up_val[PULSE_W-1:0] : dn_val;
  end

  // Mirror of the follower about the two home positions, clamped high then low.
  always_comb begin
    mirror_raw = $signed({2'b00, cfg.follower_home})
               - ($signed({2'b00, p_new}) - $signed({2'b00, cfg.leader_home}));
    mirror_hi  = (mirror_raw > $signed({2'b00, cfg.servo_max}))
               ? $signed({2'b00, cfg.servo_max}) : mirror_raw;
    if (mirror_hi < $signed({2'b00, cfg.servo_min}))
      mirror_val = cfg.servo_min;
    else
      mirror_val = mirror_hi[PULSE_W-1:0];
  end

  // Decimal accumulation of the step size, saturating at the pulse range.
  assign dv_acc = 16'(dv_r) * 16'd10 + 16'(c_off[3:0]);
  assign dv_sat = (dv_acc > 16'd4095) ? 12'd4095 : dv_acc[PULSE_W-1:0];
  assign et_inc = et_r + 1'b1;

  always_comb begin
    pos_nxt  = pos_r;
    sel_nxt  = sel_r;
    step_nxt = step_r;
    coll_nxt = coll_r;
    dv_nxt   = dv_r;
    et_nxt   = et_r;
    res      = '0;
    res.event_res = EV_NONE;

    unique case (item.op)
      OP_BYTE: begin
        if (coll_r) begin
          if (is_digit) begin
            dv_nxt = dv_sat;
          end else begin
            coll_nxt = 1'b0;
            dv_nxt   = '0;
            et_nxt   = '0;
            if (dv_r != '0) begin
              step_nxt      = dv_r;
              res.event_res = EV_STEP_SET;
            end else begin
              res.event_res = EV_STEP_REJ;
            end
          end
        end else if (is_sel) begin
          sel_nxt       = c_off[SEL_W-1:0];
          res.event_res = EV_SELECTED;
          res.channel   = 3'(c_off[SEL_W-1:0]);
          res.pulse     = pos_r[c_off[SEL_W-1:0]];
        end else if (is_up || is_down) begin
          pos_nxt[sel_r] = p_new;
          res.event_res  = EV_MOVED;
          res.channel    = 3'(sel_r);
          res.pulse      = p_new;
          if (sel_r == SEL_W'(LEADER_IDX)) begin
            pos_nxt[FOLLOWER_IDX] = mirror_val;
            res.follower_moved    = 1'b1;
            res.follower_pulse    = mirror_val;
          end
        end else if ((c == CH_STEP_U) || (c == CH_STEP_L)) begin
          coll_nxt = 1'b1;
          dv_nxt   = '0;
          et_nxt   = '0;
        end else if ((c == CH_EXIT_U) || (c == CH_EXIT_L)) begin
          res.event_res = EV_EXIT;
        end
      end
      OP_TICK: begin
        if (coll_r) begin
          et_nxt = et_inc;
          // A wrapped count also ends entry; a timeout of zero fires on the first tick.
          if ((et_inc >= cfg.digit_timeout) || (et_inc == '0)) begin
            coll_nxt = 1'b0;
            dv_nxt   = '0;
            et_nxt   = '0;
            if (dv_r != '0) begin
              step_nxt      = dv_r;
              res.event_res = EV_STEP_SET;
            end else begin
              res.event_res = EV_STEP_REJ;
            end
          end
        end
      end
      OP_RESTART: begin
        for (int i = 0; i < SERVO_COUNT; i++) begin
          pos_nxt[i] = home_pulse(i, cfg);
        end
        sel_nxt       = '0;
        coll_nxt      = 1'b0;
        dv_nxt        = '0;
        et_nxt        = '0;
        res.event_res = EV_RESTARTED;
        res.channel   = 3'd0;
        res.pulse     = FIXED_HOME[0];
      end
      OP_IDLE: ;
    endcase

    res.step_now = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        if (i < 4)                  pos_r[i] <= FIXED_HOME[i];
        else if (i == LEADER_IDX)   pos_r[i] <= RST_LEADER_HOME;
        else if (i == FOLLOWER_IDX) pos_r[i] <= RST_FOLLOWER_HOME;
        else                        pos_r[i] <= RST_SERVO_MIN;
      end
      sel_r  <= '0;
      step_r <= RST_STEP;
      coll_r <= 1'b0;
      dv_r   <= '0;
      et_r   <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      sel_r  <= sel_nxt;
      step_r <= step_nxt;
      coll_r <= coll_nxt;
      dv_r   <= dv_nxt;
      et_r   <= et_nxt;
    end
  end

  assign result = res;

endmodule

// ===== hdl/sjci_out_buf.sv =====
// Two-entry output register with skid stage for result transactions.
`timescale 1ns / 1ps

module sjci_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sjci_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sjci_pkg::result_t out_data
);
  import sjci_pkg::*;

  result_t main_r, skid_r;
  logic    main_v_r, skid_v_r;
  logic    pop;

  assign pop        = main_v_r && out_ready;
  assign push_ready = !skid_v_r;

  // Control flags: the skid entry only fills while the main entry is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop && skid_v_r) begin
        skid_v_r <= 1'b0;
      end else if (pop || !main_v_r) begin
        main_v_r <= push;
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_r <= skid_r;
    end else if (pop || !main_v_r) begin
      if (push) main_r <= push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

// ===== hdl/servo_jog_command_interpreter.sv =====
// Top level of the servo jog command interpreter.
`timescale 1ns / 1ps

// The interpreter takes one transaction per clock cycle on the input channel
// while in_ready is high: a received command byte, a millisecond tick or a
// restart, and returns exactly one result transaction for each, in order,
// through a registered output. All state (servo pulses, selected servo, step size
// and digit entry) updates in the accepting cycle through a single short pass of
// add, clamp and mirror logic, so back-to-back transactions need no wait. Results
// leave through an output register backed by a skid stage; in_ready drops only
// when both hold results that the consumer has not yet taken. Configuration
// writes are registered and are meant to be issued while the block is idle.
// After reset the servos sit at 430, 190, 510, 440, 600 and 150, any further
// servo at 150, the step size is 5 and servo 0 is selected.

module servo_jog_command_interpreter #(
  parameter int SERVO_COUNT = sjci_pkg::SERVO_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sjci_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sjci_pkg::result_t               out_data,
  input  logic                            cfg_we,
  input  logic [sjci_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sjci_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sjci_pkg::*;

  cfg_t    cfg;
  result_t core_result;
  logic    in_accept;

  // A transaction is taken whenever the skid stage has room for its result.
  assign in_accept = in_valid && in_ready;

  sjci_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The core updates its state in the same cycle that it produces the result.
  sjci_core #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (core_result)
  );

  sjci_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (core_result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== verif/servo_jog_command_interpreter_tb.sv =====
// Self-checking testbench for the servo jog command interpreter.
`timescale 1ns / 1ps

module testbench;
  import sjci_pkg::*;

  // Number of servos in the instance under test.
  localparam int SERVOS = SERVO_COUNT_DEF;

  // Register index that the block does not decode; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Command characters understood by the interpreter.
  localparam logic [7:0] KEY_ZERO    = "0";
  localparam logic [7:0] KEY_NINE    = "9";
  localparam logic [7:0] KEY_UP      = "D";
  localparam logic [7:0] KEY_UP_LC   = "d";
  localparam logic [7:0] KEY_PLUS    = "+";
  localparam logic [7:0] KEY_DOWN    = "A";
  localparam logic [7:0] KEY_DOWN_LC = "a";
  localparam logic [7:0] KEY_MINUS   = "-";
  localparam logic [7:0] KEY_STEP    = "s";
  localparam logic [7:0] KEY_STEP_UC = "S";
  localparam logic [7:0] KEY_EXIT    = "m";
  localparam logic [7:0] KEY_EXIT_UC = "M";
  localparam logic [7:0] KEY_DOT     = ".";
  localparam logic [7:0] KEY_X       = "x";
  localparam logic [7:0] JOG_KEYS [6] = '{KEY_UP, KEY_UP_LC, KEY_PLUS,
                                          KEY_DOWN, KEY_DOWN_LC, KEY_MINUS};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  result_t               out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  servo_jog_command_interpreter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the interpreter state, advanced once per accepted transaction.
  cfg_t               setting;
  logic [PULSE_W-1:0] servo_pos [SERVOS];
  logic [2:0]         chosen_servo;
  logic [PULSE_W-1:0] step_amount;
  logic               in_step_entry;
  logic [PULSE_W-1:0] entry_value;
  logic [TIMEOUT_W-1:0] entry_ticks;

  // Results predicted for accepted transactions, oldest first.
  result_t pending_results [$];

  int  mismatches = 0;
  int  accepted_items = 0;

  // Traffic shaping knobs shared by the test tasks and the result-side process.
  bit  tx_gapless;
  bit  rx_gapless;
  int  rx_hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL servo_jog_command_interpreter");
    $finish;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Servos 0 to 3 have fixed homes; 4 and 5 take theirs from the registers.
  function automatic void load_home_positions();
    for (int i = 0; i < SERVOS; i++) begin
      if (i < 4) servo_pos[i] = FIXED_HOME[i];
      else if (i == 4) servo_pos[i] = setting.leader_home;
      else if (i == 5) servo_pos[i] = setting.follower_home;
      else servo_pos[i] = setting.servo_min;
    end
  endfunction

  // Ends step size entry, whether by a non-digit byte or by the tick timeout.
  // A collected value of zero leaves the step size alone and is reported as rejected.
  function automatic event_t close_step_entry();
    event_t ev;
    if (entry_value > 0) begin
      step_amount = entry_value;
      ev = EV_STEP_SET;
    end else begin
      ev = EV_STEP_REJ;
    end
    in_step_entry = 1'b0;
    entry_value = '0;
    entry_ticks = '0;
    return ev;
  endfunction

  // Computes the result of one transaction and advances the shadow state.
  function automatic result_t predict_jog_result(in_item_t item);
    result_t    res;
    logic [7:0] b;
    bit         up, down;
    int         p, f, nv;
    res = '0;
    b = item.byte_value;
    up = (b == KEY_UP) || (b == KEY_UP_LC) || (b == KEY_PLUS);
    down = (b == KEY_DOWN) || (b == KEY_DOWN_LC) || (b == KEY_MINUS);
    case (item.op)
      OP_BYTE: begin
        if (in_step_entry) begin
          // During step entry no byte is a command; digits accumulate, anything
          // else closes the entry and is swallowed.
          if (b >= KEY_ZERO && b <= KEY_NINE) begin
            nv = int'(entry_value) * 10 + int'(b - KEY_ZERO);
            entry_value = (nv > 4095) ? 12'd4095 : 12'(nv);
          end else begin
            res.event_res = close_step_entry();
          end
        end else if (b >= KEY_ZERO && b < KEY_ZERO + SERVOS) begin
          chosen_servo = 3'(b - KEY_ZERO);
          res.event_res = EV_SELECTED;
          res.channel = chosen_servo;
          res.pulse = servo_pos[chosen_servo];
        end else if (up || down) begin
          p = servo_pos[chosen_servo];
          if (up) begin
            // A pulse already above the maximum drops to it.
            if (p < setting.servo_max) p = p + step_amount;
            if (p > setting.servo_max) p = setting.servo_max;
          end else begin
            // Stepping down never wraps below zero, and ends at least at the minimum.
            if (p > setting.servo_min) p = (step_amount > p) ? 0 : p - step_amount;
            if (p < setting.servo_min) p = setting.servo_min;
          end
          servo_pos[chosen_servo] = 12'(p);
          res.event_res = EV_MOVED;
          res.channel = chosen_servo;
          res.pulse = 12'(p);
          if (chosen_servo == 3'd4) begin
            // Servo 5 mirrors servo 4 about the two homes; the minimum wins last.
            f = int'(setting.follower_home) - (p - int'(setting.leader_home));
            if (f > int'(setting.servo_max)) f = int'(setting.servo_max);
            if (f < int'(setting.servo_min)) f = int'(setting.servo_min);
            servo_pos[5] = 12'(f);
            res.follower_moved = 1'b1;
            res.follower_pulse = 12'(f);
          end
        end else if (b == KEY_STEP || b == KEY_STEP_UC) begin
          in_step_entry = 1'b1;
          entry_value = '0;
          entry_ticks = '0;
        end else if (b == KEY_EXIT || b == KEY_EXIT_UC) begin
          res.event_res = EV_EXIT;
        end
      end
      OP_TICK: begin
        if (in_step_entry) begin
          entry_ticks = entry_ticks + 1'b1;
          if (entry_ticks >= setting.digit_timeout || entry_ticks == 0)
            res.event_res = close_step_entry();
        end
      end
      OP_RESTART: begin
        load_home_positions();
        chosen_servo = '0;
        in_step_entry = 1'b0;
        entry_value = '0;
        entry_ticks = '0;
        res.event_res = EV_RESTARTED;
        res.channel = '0;
        res.pulse = servo_pos[0];
      end
      default: ;
    endcase
    res.step_now = step_amount;
    return res;
  endfunction

  // Offers one transaction after a random gap (none when tx_gapless is set) and records its expected result
  // at the edge where it is accepted. Valid stays high across back-to-back sends.
  task automatic send_item(op_t op, logic [7:0] value);
    in_item_t item;
    int       gap;
    item.op = op;
    item.byte_value = value;
    gap = tx_gapless ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_jog_result(item));
    if (op != OP_IDLE) accepted_items++;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes one register and mirrors the write in the shadow configuration.
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SERVO_MIN:     setting.servo_min = value;
      REG_SERVO_MAX:     setting.servo_max = value;
      REG_LEADER_HOME:   setting.leader_home = value;
      REG_FOLLOWER_HOME: setting.follower_home = value;
      REG_DIGIT_TIMEOUT: setting.digit_timeout = value[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // Loads a full register set once the block has gone quiet.
  task automatic apply_settings(logic [PULSE_W-1:0] lo, logic [PULSE_W-1:0] hi,
                                logic [PULSE_W-1:0] lead, logic [PULSE_W-1:0] follow,
                                logic [TIMEOUT_W-1:0] ticks);
    wait_idle();
    write_setting(REG_SERVO_MIN, lo);
    write_setting(REG_SERVO_MAX, hi);
    write_setting(REG_LEADER_HOME, lead);
    write_setting(REG_FOLLOWER_HOME, follow);
    write_setting(REG_DIGIT_TIMEOUT, {2'b00, ticks});
  endtask

  // Command bytes at the reset settings: exit, noise, selection inside and just
  // past the servo range, every jog key, the servo 4 linkage at both range ends,
  // an idle op, a stray tick and a saturating step size.
  task automatic test_commands();
    send_item(OP_BYTE, KEY_EXIT);
    send_item(OP_BYTE, KEY_EXIT_UC);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, KEY_ZERO + 8'd5);
    send_item(OP_BYTE, KEY_ZERO + 8'(SERVOS));
    send_item(OP_BYTE, KEY_PLUS);
    send_item(OP_BYTE, KEY_ZERO + 8'd4);
    send_item(OP_BYTE, KEY_UP);
    send_item(OP_BYTE, KEY_DOWN_LC);
    send_item(OP_BYTE, KEY_DOWN);
    send_item(OP_IDLE, 8'hA5);
    send_item(OP_TICK, 8'h5A);
    send_item(OP_BYTE, KEY_STEP);
    repeat (5) send_item(OP_BYTE, KEY_NINE);
    send_item(OP_BYTE, KEY_X);
    // A step of 4095 drives servo 4 through both clamps and the mirror with it.
    send_item(OP_BYTE, KEY_MINUS);
    send_item(OP_BYTE, KEY_UP_LC);
  endtask

  // Step entry ended by the tick timeout, by a non-digit, rejected at zero and
  // cancelled by restart; also a wide timeout write and an undecoded index.
  task automatic test_step_timeout();
    wait_idle();
    // Only the low ten bits of the timeout register are kept, so this is one tick.
    write_setting(REG_DIGIT_TIMEOUT, 12'h401);
    write_setting(REG_UNUSED, 12'hFFF);
    send_item(OP_BYTE, KEY_STEP);
    send_item(OP_BYTE, KEY_ZERO + 8'd7);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, KEY_STEP_UC);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, KEY_STEP);
    send_item(OP_BYTE, KEY_ZERO);
    send_item(OP_BYTE, KEY_DOT);
    wait_idle();
    write_setting(REG_DIGIT_TIMEOUT, 12'd3);
    send_item(OP_BYTE, KEY_STEP);
    send_item(OP_BYTE, KEY_ZERO + 8'd1);
    send_item(OP_BYTE, KEY_ZERO + 8'd2);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, KEY_ZERO + 8'd3);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, KEY_STEP);
    send_item(OP_BYTE, KEY_ZERO + 8'd4);
    send_item(OP_RESTART, 8'h00);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // back to back, so the output stages fill and in_ready has to drop.
  task automatic test_backpressure();
    rx_hold_request = 200;
    tx_gapless = 1'b1;
    repeat (24)
      send_item(OP_BYTE, $urandom_range(0, 1) ? JOG_KEYS[$urandom_range(0, 5)]
                                               : KEY_ZERO + 8'($urandom_range(0, SERVOS - 1)));
    tx_gapless = 1'b0;
    wait_idle();
  endtask

  // Random traffic, mostly well formed: selections, jogs and complete step
  // entries with random digits, plus exits, restarts, ticks and noise bytes.
  task automatic run_random_items(int count);
    int         first, kind, digits;
    logic [7:0] b;
    first = accepted_items;
    while (accepted_items - first < count) begin
      // Now and then switch either side between random gaps and full rate.
      if ($urandom_range(0, 39) == 0) begin
        tx_gapless = ($urandom_range(0, 3) == 0);
        rx_gapless = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        send_item(OP_BYTE, KEY_ZERO + 8'($urandom_range(0, SERVOS - 1)));
      end else if (kind < 55) begin
        send_item(OP_BYTE, JOG_KEYS[$urandom_range(0, 5)]);
      end else if (kind < 72) begin
        send_item(OP_BYTE, $urandom_range(0, 1) ? KEY_STEP : KEY_STEP_UC);
        digits = $urandom_range(0, 5);
        for (int i = 0; i < digits; i++) begin
          if ($urandom_range(0, 5) == 0) send_item(OP_TICK, 8'($urandom));
          send_item(OP_BYTE, KEY_ZERO + 8'($urandom_range(0, 9)));
        end
        // Short timeouts are worth running out; long ones end on a non-digit.
        if (setting.digit_timeout <= 16 && $urandom_range(0, 1) == 1) begin
          repeat (setting.digit_timeout) send_item(OP_TICK, 8'($urandom));
        end else begin
          do b = 8'($urandom); while (b >= KEY_ZERO && b <= KEY_NINE);
          send_item(OP_BYTE, b);
        end
      end else if (kind < 80) begin
        send_item(OP_BYTE, $urandom_range(0, 1) ? KEY_EXIT : KEY_EXIT_UC);
      end else if (kind < 84) begin
        send_item(OP_RESTART, 8'($urandom));
      end else if (kind < 88) begin
        send_item(OP_TICK, 8'($urandom));
      end else if (kind < 90) begin
        send_item(OP_IDLE, 8'($urandom));
      end else begin
        send_item(OP_BYTE, 8'($urandom));
      end
    end
  endtask

  // Random traffic under several register sets: the settings left by the
  // directed tests, the widest range, an inverted range with homes outside it,
  // and two random ordered ranges with short timeouts.
  task automatic test_random_settings();
    int lo;
    run_random_items(140);
    apply_settings(12'd0, 12'd4095, 12'd4095, 12'd0, 10'd1023);
    run_random_items(140);
    apply_settings(12'd4095, 12'd0, 12'd0, 12'd4095, 10'd1);
    run_random_items(100);
    repeat (2) begin
      lo = $urandom_range(0, 2000);
      apply_settings(12'(lo), 12'(lo + $urandom_range(0, 2000)), 12'($urandom),
                     12'($urandom), 10'($urandom_range(1, 12)));
      run_random_items(160);
    end
  endtask

  // Result side: random short stalls, full-rate stretches, and the long
  // hold-off requested by the backpressure test, counted here in cycles.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_request > 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_gapless && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction waiting, event %0d",
               out_data.event_res);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", want.event_res, out_data.event_res);
        check_field("channel", want.channel, out_data.channel);
        check_field("pulse", want.pulse, out_data.pulse);
        check_field("follower_moved", want.follower_moved, out_data.follower_moved);
        check_field("follower_pulse", want.follower_pulse, out_data.follower_pulse);
        check_field("step_now", want.step_now, out_data.step_now);
      end
    end
  end

  initial begin : run_tests
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    tx_gapless = 1'b0;
    rx_gapless = 1'b0;
    rx_hold_request = 0;

    // Shadow state as the block comes out of reset.
    setting.servo_min = RST_SERVO_MIN;
    setting.servo_max = RST_SERVO_MAX;
    setting.leader_home = RST_LEADER_HOME;
    setting.follower_home = RST_FOLLOWER_HOME;
    setting.digit_timeout = RST_DIGIT_TIMEOUT;
    load_home_positions();
    chosen_servo = '0;
    step_amount = RST_STEP;
    in_step_entry = 1'b0;
    entry_value = '0;
    entry_ticks = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_commands();
    test_step_timeout();
    test_backpressure();
    test_random_settings();

    // Everything predicted has arrived; give stray results a chance to show up.
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS servo_jog_command_interpreter");
    end else begin
      $display("FAIL servo_jog_command_interpreter");
    end
    $finish;
  end

endmodule
